FILE: design/hash_preimage_bruteforce_top_assert.svh
// Assertion macros shared by the preimage search modules.
`ifndef HASH_PREIMAGE_BRUTEFORCE_TOP_ASSERT_SVH
`define HASH_PREIMAGE_BRUTEFORCE_TOP_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define HPB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define HPB_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define HPB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/hpb_pkg.sv
// Types, constants and constant tables of the preimage search.
package hpb_pkg;

    localparam int MAX_LEN_LIMIT = 8;
    localparam int TAB_IDX_W     = 4;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CHAR_FIELDS   = 5;

    localparam logic [63:0] HASH_SEED   = 64'h1234;
    localparam logic [63:0] HASH_MUL    = 64'd33;
    localparam logic [63:0] LETTER_BASE = 64'd97;
    localparam logic [6:0]  CHAR_BIAS   = 7'd96;
    localparam logic [4:0]  LETTER_SPAN = 5'd26;

    typedef logic [MAX_LEN_LIMIT:0][63:0] t_tab;

    typedef enum logic [1:0] {
        S_IDLE,
        S_OFFSET,
        S_RANGE,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic        valid;
        logic [63:0] target;
    } t_job;

    // Powers of 33, indexed by exponent.
    function automatic t_tab pow_table();
        t_tab        tab;
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k <= MAX_LEN_LIMIT; k++) begin
            tab[k] = p;
            p      = p * HASH_MUL;
        end
        return tab;
    endfunction

    // Hash of the all-'a' string of each length minus the letter offsets,
    // i.e. seed*33^len + 97*(33^(len-1)+...+1), modulo 2^64.
    function automatic t_tab offset_table();
        t_tab        tab;
        logic [63:0] p;
        logic [63:0] ones;
        p    = 64'd1;
        ones = 64'd0;
        for (int k = 0; k <= MAX_LEN_LIMIT; k++) begin
            tab[k] = HASH_SEED * p + LETTER_BASE * ones;
            p      = p * HASH_MUL;
            ones   = ones * HASH_MUL + 64'd1;
        end
        return tab;
    endfunction

endpackage

FILE: design/hpb_front.sv
// Request intake: accepts targets and buffers them in a short queue.
module hpb_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [63:0]  i_target_hash,
    output hpb_pkg::t_job o_job,
    input  logic         i_pop
);
    import hpb_pkg::*;

    `include "hash_preimage_bruteforce_top_assert.svh"

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [63:0]      r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_stall      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_push       = i_valid && !o_stall;
    assign w_pop        = i_pop && o_job.valid;
    assign o_job.valid  = (r_count != '0);
    assign o_job.target = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_target_hash;
        end
    end

    `HPB_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `HPB_ASSERT_IMPLY(a_pop_nonempty, i_pop, r_count != '0, "pop from empty queue")
    `HPB_ASSERT_NEXT(a_push_grows, w_push && !w_pop, r_count == $past(r_count) + 1'b1, "push lost")

endmodule

FILE: design/hpb_search.sv
// Search engine: tests each length in closed form and extracts the letters.
module hpb_search #(
    parameter int MAX_LENGTH = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hpb_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic          o_found,
    output logic [2:0]    o_length,
    output logic [6:0]    o_char_0,
    output logic [6:0]    o_char_1,
    output logic [6:0]    o_char_2,
    output logic [6:0]    o_char_3,
    output logic [6:0]    o_char_4
);
    import hpb_pkg::*;

    `include "hash_preimage_bruteforce_top_assert.svh"

    localparam int   LEN_W     = $clog2(MAX_LENGTH + 1);
    localparam int   DIG_IDX_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam t_tab PW_TAB    = pow_table();
    localparam t_tab OFS_TAB   = offset_table();

    t_state                r_state, n_state;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [TAB_IDX_W-1:0]  r_pidx, n_pidx;
    logic [DIG_IDX_W-1:0]  r_didx, n_didx;
    logic [4:0]            r_q, n_q;
    logic [63:0]           r_d, n_d;
    logic [63:0]           r_target, n_target;
    logic [4:0]            r_dig [MAX_LENGTH];
    logic [4:0]            n_dig [MAX_LENGTH];

    logic                  r_out_valid;
    logic                  r_found;
    logic [2:0]            r_length;
    logic [6:0]            r_chars [CHAR_FIELDS];

    logic [TAB_IDX_W-1:0]  w_len_idx;
    logic [64:0]           w_sub;
    logic                  w_fin;
    logic                  w_fin_found;
    logic                  w_next_len;
    logic [6:0]            w_char [CHAR_FIELDS];

    assign w_len_idx = TAB_IDX_W'(r_len);
    // Borrow out of this subtraction means the remainder is below the power.
    assign w_sub     = {1'b0, r_d} - {1'b0, PW_TAB[r_pidx]};

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_pidx      = r_pidx;
        n_didx      = r_didx;
        n_q         = r_q;
        n_d         = r_d;
        n_target    = r_target;
        n_dig       = r_dig;
        o_pop       = 1'b0;
        w_fin       = 1'b0;
        w_fin_found = 1'b0;
        w_next_len  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job.valid && !r_out_valid) begin
                    o_pop    = 1'b1;
                    n_target = i_job.target;
                    n_len    = LEN_W'(1);
                    n_state  = S_OFFSET;
                end
            end
            S_OFFSET: begin
                n_d     = r_target - OFS_TAB[w_len_idx];
                n_state = S_RANGE;
            end
            S_RANGE: begin
                if (r_d < PW_TAB[w_len_idx]) begin
                    n_pidx  = TAB_IDX_W'(w_len_idx - TAB_IDX_W'(1));
                    n_didx  = '0;
                    n_q     = '0;
                    n_state = S_DIGIT;
                end else begin
                    w_next_len = 1'b1;
                end
            end
            S_DIGIT: begin
                if (!w_sub[64]) begin
                    // A 26th subtraction would mean a digit that is no letter.
                    if (r_q == LETTER_SPAN - 5'd1) begin
                        w_next_len = 1'b1;
                    end else begin
                        n_d = w_sub[63:0];
                        n_q = r_q + 5'd1;
                    end
                end else begin
                    n_dig[r_didx] = r_q + 5'd1;
                    n_q           = '0;
                    if (r_pidx == '0) begin
                        w_fin       = 1'b1;
                        w_fin_found = 1'b1;
                    end else begin
                        n_pidx = r_pidx - 1'b1;
                        n_didx = r_didx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_next_len) begin
            if (r_len == LEN_W'(MAX_LENGTH)) begin
                w_fin = 1'b1;
            end else begin
                n_len   = r_len + 1'b1;
                n_state = S_OFFSET;
            end
        end
        if (w_fin) begin
            n_state = S_IDLE;
        end
    end

    for (genvar g = 0; g < CHAR_FIELDS; g++) begin : g_char
        if (g < MAX_LENGTH) begin : g_used
            assign w_char[g] = (TAB_IDX_W'(g) < w_len_idx) ?
                               CHAR_BIAS + 7'(n_dig[g]) : 7'd0;
        end else begin : g_unused
            assign w_char[g] = 7'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_pidx   <= n_pidx;
        r_didx   <= n_didx;
        r_q      <= n_q;
        r_d      <= n_d;
        r_target <= n_target;
        r_dig    <= n_dig;
        if (w_fin) begin
            r_found  <= w_fin_found;
            r_length <= w_fin_found ? 3'(r_len) : 3'd0;
            for (int k = 0; k < CHAR_FIELDS; k++) begin
                r_chars[k] <= w_fin_found ? w_char[k] : 7'd0;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_found  = r_found;
    assign o_length = r_length;
    assign o_char_0 = r_chars[0];
    assign o_char_1 = r_chars[1];
    assign o_char_2 = r_chars[2];
    assign o_char_3 = r_chars[3];
    assign o_char_4 = r_chars[4];

    `HPB_ASSERT_IMPLY(a_nf_zero, o_valid && !o_found, o_length == 3'd0 && o_char_0 == 7'd0, "miss not zero")
    `HPB_ASSERT_IMPLY(a_pop_free, o_pop, !r_out_valid && r_state == S_IDLE, "job taken while busy")
    `HPB_ASSERT_ALWAYS(a_digit_bound, r_state != S_DIGIT || r_q < LETTER_SPAN, "digit out of range")
    `HPB_ASSERT_NEXT(a_fin_valid, w_fin, o_valid && r_state == S_IDLE, "result not posted")

endmodule

FILE: design/hash_preimage_bruteforce_top.sv
// Each length costs one offset subtract and one range compare, then compare-subtract steps.
// One request per search: the engine takes the next one the cycle after its result
// transaction, and a two-entry queue buffers the requests that wait.
// Reset (synchronous, active low) empties the queue, idles the engine and drops any result.
module hash_preimage_bruteforce_top #(
    parameter int MAX_LENGTH = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_target_hash,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [2:0]  o_length,
    output logic [6:0]  o_char_0,
    output logic [6:0]  o_char_1,
    output logic [6:0]  o_char_2,
    output logic [6:0]  o_char_3,
    output logic [6:0]  o_char_4
);
    import hpb_pkg::*;

    t_job w_job;
    logic w_pop;

    hpb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_target_hash (i_target_hash),
        .o_job         (w_job),
        .i_pop         (w_pop)
    );

    hpb_search #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_job),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_found  (o_found),
        .o_length (o_length),
        .o_char_0 (o_char_0),
        .o_char_1 (o_char_1),
        .o_char_2 (o_char_2),
        .o_char_3 (o_char_3),
        .o_char_4 (o_char_4)
    );

endmodule
